@@ design/msvs_pkg.sv @@
// shared types, constants and the cordic arctangent table for the mandelbulb voxel scan
// no dependencies
package msvs_pkg;

   localparam int GRID_SIZE_DEF      = 128;
   localparam int POINT_CAPACITY_DEF = 2097152;
   localparam int ITER_LIMIT_RESET   = 20;
   localparam int CORDIC_STEPS       = 22;
   localparam int CORDIC_W           = 28;
   localparam int ANGLE_W            = 33;
   localparam int CORDIC_K           = 2547003;

   typedef logic signed [31:0]         q22_type;
   typedef logic signed [CORDIC_W-1:0] cval_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_SQA, ST_CHECK, ST_R4, ST_R8,
      ST_VEC1, ST_RHO, ST_VEC2, ST_ROT1, ST_ROT2, ST_MT, ST_MX, ST_MY, ST_MZ,
      ST_DONE
   } iter_state_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic       escaped;
      logic [6:0] steps;
   } iter_status_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // floor the q22 product, add the offset and clamp into q10.22
   function automatic q22_type clamp_add(input logic signed [63:0] p, input q22_type c);
      logic signed [42:0] v;
      v = $signed({p[63], p[63:22]}) + $signed({{11{c[31]}}, c});
      if (v > 43'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -43'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

@@ design/msvs_cordic.sv @@
// shared cordic unit, one micro-rotation per clock, vectoring or rotation mode
// depends on msvs_pkg
module msvs_cordic
   import msvs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cordic_cmd_type cmd,
   input  cval_type       x_in,
   input  cval_type       y_in,
   input  logic [31:0]    ang_in,
   output logic           done,
   output cval_type       x_out,
   output cval_type       y_out,
   output logic [31:0]    ang_out
);

   localparam logic signed [ANGLE_W-1:0] QUARTER_A = 33'sd1073741824;
   localparam logic signed [ANGLE_W-1:0] HALF_A    = 33'sd2147483648;
   localparam logic [4:0]                LAST_STEP = 5'(CORDIC_STEPS - 1);

   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [4:0]                step_ff, step_in;
   cval_type                  x_ff, x_in_r, y_ff, y_in_r;
   logic signed [ANGLE_W-1:0] a_ff, a_in;
   logic                      vec_ff, vec_in;
   logic                      flip_ff, flip_in;
   logic                      zero_ff, zero_in;

   logic signed [ANGLE_W-1:0] a_ext;
   logic signed [ANGLE_W-1:0] t;
   cval_type                  xs, ys;
   logic                      cw;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in_r  = x_ff;
      y_in_r  = y_ff;
      a_in    = a_ff;
      vec_in  = vec_ff;
      flip_in = flip_ff;
      zero_in = zero_ff;
      a_ext   = $signed({ang_in[31], ang_in});
      t       = $signed({1'b0, atan_entry(step_ff)});
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      cw      = vec_ff ? (!y_ff[CORDIC_W-1] && (y_ff != '0)) : a_ff[ANGLE_W-1];
      if (cmd.start) begin
         run_in  = 1'b1;
         step_in = '0;
         vec_in  = cmd.vectoring;
         flip_in = 1'b0;
         zero_in = 1'b0;
         if (cmd.vectoring) begin
            zero_in = (x_in == '0) && (y_in == '0);
            if (x_in[CORDIC_W-1]) begin
               x_in_r = -x_in;
               y_in_r = -y_in;
               a_in   = HALF_A;
            end else begin
               x_in_r = x_in;
               y_in_r = y_in;
               a_in   = '0;
            end
         end else begin
            x_in_r = CORDIC_W'(CORDIC_K);
            y_in_r = '0;
            a_in   = a_ext;
            // fold into plus or minus a quarter turn
            if (a_ext > QUARTER_A) begin
               a_in    = a_ext - HALF_A;
               flip_in = 1'b1;
            end else if (a_ext < -QUARTER_A) begin
               a_in    = a_ext + HALF_A;
               flip_in = 1'b1;
            end
         end
      end else if (run_ff) begin
         if (cw) begin
            x_in_r = x_ff + ys;
            y_in_r = y_ff - xs;
            a_in   = a_ff + t;
         end else begin
            x_in_r = x_ff - ys;
            y_in_r = y_ff + xs;
            a_in   = a_ff - t;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in_r;
      y_ff    <= y_in_r;
      a_ff    <= a_in;
      vec_ff  <= vec_in;
      flip_ff <= flip_in;
      zero_ff <= zero_in;
   end

   assign done    = done_ff;
   assign x_out   = zero_ff ? '0 : (flip_ff ? -x_ff : x_ff);
   assign y_out   = zero_ff ? '0 : (flip_ff ? -y_ff : y_ff);
   assign ang_out = zero_ff ? '0 : a_ff[31:0];

endmodule

@@ design/msvs_iter.sv @@
// escape-time sequencer for one voxel: shared multiplier plus the cordic unit
// depends on msvs_pkg and msvs_cordic
module msvs_iter
   import msvs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  q22_type         cx,
   input  q22_type         cy,
   input  q22_type         cz,
   input  logic [5:0]      iter_limit,
   input  logic            ack,
   output iter_status_type status
);

   localparam logic [63:0] ESC_LIMIT = 64'h0000_4000_0000_0000;
   localparam q22_type     K_Q       = 32'(CORDIC_K);

   iter_state_type    state_ff, state_in;
   q22_type           zx_ff, zx_in, zy_ff, zy_in, zz_ff, zz_in;
   logic [63:0]       sum_ff, sum_in;
   logic [6:0]        steps_ff, steps_in;
   logic              esc_ff, esc_in;
   q22_type           r8_ff, r8_in, tmp_ff, tmp_in;
   logic [31:0]       phi_ff, phi_in;
   cval_type          c8t_ff, c8t_in, s8t_ff, s8t_in, c8p_ff, c8p_in, s8p_ff, s8p_in;
   logic signed [63:0] prod_ff;
   q22_type           mul_a, mul_b;

   cordic_cmd_type    ccmd;
   cval_type          cx_in, cy_in;
   logic [31:0]       cang_in;
   logic              cdone;
   cval_type          cx_out, cy_out;
   logic [31:0]       cang_out;

   msvs_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ccmd),
      .x_in    (cx_in),
      .y_in    (cy_in),
      .ang_in  (cang_in),
      .done    (cdone),
      .x_out   (cx_out),
      .y_out   (cy_out),
      .ang_out (cang_out)
   );

   always_comb begin
      state_in = state_ff;
      zx_in    = zx_ff;
      zy_in    = zy_ff;
      zz_in    = zz_ff;
      sum_in   = sum_ff;
      steps_in = steps_ff;
      esc_in   = esc_ff;
      r8_in    = r8_ff;
      tmp_in   = tmp_ff;
      phi_in   = phi_ff;
      c8t_in   = c8t_ff;
      s8t_in   = s8t_ff;
      c8p_in   = c8p_ff;
      s8p_in   = s8p_ff;
      mul_a    = zx_ff;
      mul_b    = zx_ff;
      ccmd     = '0;
      cx_in    = zx_ff[CORDIC_W-1:0];
      cy_in    = zy_ff[CORDIC_W-1:0];
      cang_in  = {cang_out[28:0], 3'b000};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               zx_in    = '0;
               zy_in    = '0;
               zz_in    = '0;
               steps_in = '0;
               esc_in   = 1'b0;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sum_in   = prod_ff;
            mul_a    = zy_ff;
            mul_b    = zy_ff;
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            sum_in   = sum_ff + prod_ff;
            mul_a    = zz_ff;
            mul_b    = zz_ff;
            state_in = ST_SQA;
         end
         ST_SQA: begin
            sum_in   = sum_ff + prod_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            steps_in = steps_ff + 7'd1;
            mul_a    = {7'b0, sum_ff[46:22]};
            mul_b    = {7'b0, sum_ff[46:22]};
            if (sum_ff > ESC_LIMIT) begin
               esc_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_R4;
            end
         end
         ST_R4: begin
            mul_a    = prod_ff[53:22];
            mul_b    = prod_ff[53:22];
            state_in = ST_R8;
         end
         ST_R8: begin
            r8_in          = prod_ff[53:22];
            ccmd.start     = 1'b1;
            ccmd.vectoring = 1'b1;
            state_in       = ST_VEC1;
         end
         ST_VEC1: begin
            mul_a = {{(32-CORDIC_W){cx_out[CORDIC_W-1]}}, cx_out};
            mul_b = K_Q;
            if (cdone) begin
               phi_in   = cang_out;
               state_in = ST_RHO;
            end
         end
         ST_RHO: begin
            // rho from the registered magnitude product
            ccmd.start     = 1'b1;
            ccmd.vectoring = 1'b1;
            cx_in          = zz_ff[CORDIC_W-1:0];
            cy_in          = prod_ff[22+CORDIC_W-1:22];
            state_in       = ST_VEC2;
         end
         ST_VEC2: begin
            if (cdone) begin
               ccmd.start = 1'b1;
               state_in   = ST_ROT1;
            end
         end
         ST_ROT1: begin
            cang_in = {phi_ff[28:0], 3'b000};
            if (cdone) begin
               c8t_in     = cx_out;
               s8t_in     = cy_out;
               ccmd.start = 1'b1;
               state_in   = ST_ROT2;
            end
         end
         ST_ROT2: begin
            mul_a = r8_ff;
            mul_b = {{(32-CORDIC_W){s8t_ff[CORDIC_W-1]}}, s8t_ff};
            if (cdone) begin
               c8p_in   = cx_out;
               s8p_in   = cy_out;
               state_in = ST_MT;
            end
         end
         ST_MT: begin
            tmp_in   = prod_ff[53:22];
            mul_a    = prod_ff[53:22];
            mul_b    = {{(32-CORDIC_W){c8p_ff[CORDIC_W-1]}}, c8p_ff};
            state_in = ST_MX;
         end
         ST_MX: begin
            zx_in    = clamp_add(prod_ff, cx);
            mul_a    = tmp_ff;
            mul_b    = {{(32-CORDIC_W){s8p_ff[CORDIC_W-1]}}, s8p_ff};
            state_in = ST_MY;
         end
         ST_MY: begin
            zy_in    = clamp_add(prod_ff, cy);
            mul_a    = r8_ff;
            mul_b    = {{(32-CORDIC_W){c8t_ff[CORDIC_W-1]}}, c8t_ff};
            state_in = ST_MZ;
         end
         ST_MZ: begin
            zz_in = clamp_add(prod_ff, cz);
            if (steps_ff > {1'b0, iter_limit}) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQX;
            end
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      zx_ff    <= zx_in;
      zy_ff    <= zy_in;
      zz_ff    <= zz_in;
      sum_ff   <= sum_in;
      steps_ff <= steps_in;
      esc_ff   <= esc_in;
      r8_ff    <= r8_in;
      tmp_ff   <= tmp_in;
      phi_ff   <= phi_in;
      c8t_ff   <= c8t_in;
      s8t_ff   <= s8t_in;
      c8p_ff   <= c8p_in;
      s8p_ff   <= s8p_in;
      prod_ff  <= mul_a * mul_b;
   end

   assign status.busy    = (state_ff != ST_IDLE);
   assign status.done    = (state_ff == ST_DONE);
   assign status.escaped = esc_ff;
   assign status.steps   = steps_ff;

endmodule

@@ design/mandelbulb_surface_voxel_scan.sv @@
// top level of the mandelbulb surface voxel scan: index mapping, column state, result register
// depends on msvs_pkg and msvs_iter
//
// usage
//    csr channel: one word sets the iteration limit (6 bits, 20 after reset), always ready;
//       write it only while the block is idle
//    req channel: one word per voxel index triple; a column comes in rising depth order and
//       depth zero starts a new column. req_ready is low while a voxel is being worked on
//    rsp channel: at most one word per voxel, the surface point and the escape count of the
//       column's last escaping voxel
// iteration
//    one escape iteration takes four 22-step passes of the shared cordic unit plus ten
//    products on the single 32x32 multiplier
// reset
//    clears the column state, the point count and the result register, and loads the limit 20
// stall
//    a waiting result sits in the output register; a voxel that finishes while it still waits
//    holds in its final state until the register is free, and req_ready stays low meanwhile
module mandelbulb_surface_voxel_scan
   import msvs_pkg::*;
#(
   parameter int GRID_SIZE      = GRID_SIZE_DEF,
   parameter int POINT_CAPACITY = POINT_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [5:0]         csr_max_iterations,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [6:0]         req_index_x,
   input  logic [6:0]         req_index_y,
   input  logic [6:0]         req_index_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic [6:0]         rsp_escape_tag
);

   localparam int CNT_W = $clog2(POINT_CAPACITY + 1);

   q22_type map_tab [128];

   for (genvar g = 0; g < 128; g++) begin : g_map
      localparam longint MV = (64'sd2 * g * 64'sd4194304) / GRID_SIZE - 64'sd4194304;
      assign map_tab[g] = MV[31:0];
   end

   function automatic logic signed [15:0] to_pos(input q22_type c);
      logic signed [38:0] p;
      logic signed [24:0] v;
      p = $signed({{7{c[31]}}, c}) * 39'sd100;
      v = p[38:14];
      if (v > 25'sd32767) begin
         return 16'sh7fff;
      end else if (v < -25'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   logic [5:0]         limit_ff, limit_in;
   logic               inside_ff, inside_in;
   logic [6:0]         last_esc_ff, last_esc_in;
   logic [CNT_W-1:0]   points_ff, points_in;
   q22_type            cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [6:0]         tag_ff, tag_in;
   logic               accept, ack;
   iter_status_type    status;

   assign csr_ready = 1'b1;
   assign req_ready = !status.busy;
   assign accept    = req_valid && req_ready;
   assign ack       = !rsp_valid_ff || rsp_ready;

   msvs_iter u_iter (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .cx         (cx_ff),
      .cy         (cy_ff),
      .cz         (cz_ff),
      .iter_limit (limit_ff),
      .ack        (ack),
      .status     (status)
   );

   always_comb begin
      limit_in     = limit_ff;
      inside_in    = inside_ff;
      last_esc_in  = last_esc_ff;
      points_in    = points_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      tag_in       = tag_ff;
      if (csr_valid) begin
         limit_in = csr_max_iterations;
      end
      if (accept) begin
         cx_in = map_tab[req_index_x];
         cy_in = map_tab[req_index_y];
         cz_in = map_tab[req_index_z];
         if (req_index_z == 7'd0) begin
            inside_in   = 1'b0;
            last_esc_in = '0;
         end
      end
      if (status.done && ack) begin
         if (status.escaped) begin
            last_esc_in = status.steps;
            inside_in   = 1'b0;
         end else if (!inside_ff && (points_ff < CNT_W'(POINT_CAPACITY))) begin
            inside_in    = 1'b1;
            points_in    = points_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            pos_x_in     = to_pos(cx_ff);
            pos_y_in     = to_pos(cy_ff);
            pos_z_in     = to_pos(cz_ff);
            tag_in       = last_esc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= 6'(ITER_LIMIT_RESET);
         inside_ff    <= 1'b0;
         last_esc_ff  <= '0;
         points_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         inside_ff    <= inside_in;
         last_esc_ff  <= last_esc_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      pos_z_ff <= pos_z_in;
      tag_ff   <= tag_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_pos_z      = pos_z_ff;
   assign rsp_escape_tag = tag_ff;

endmodule

@@ design/msvs_checker.sv @@
// port-level checks for the mandelbulb voxel scan, bound to the top level
// depends on mandelbulb_surface_voxel_scan ports only
module msvs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_pos_x,
   input logic [6:0]         rsp_escape_tag
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while a voxel is being worked on");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result word without a voxel in flight");

   a_tag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_escape_tag <= 7'd64))
      else $error("escape tag out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x)))
      else $error("stalled result word changed");

endmodule

bind mandelbulb_surface_voxel_scan msvs_checker u_msvs_checker (.*);
